// ----- rtl/sqsf_pkg.sv -----
package sqsf_pkg;

  // Table geometry.
  localparam int MAX_SHELLS     = 1024;
  localparam int MAX_TRANSFORMS = 7;
  localparam int SHELL_W        = $clog2(MAX_SHELLS);
  localparam int XFORM_W        = 3;
  localparam int TABLE_DEPTH    = MAX_TRANSFORMS * MAX_SHELLS;
  localparam int TABLE_AW       = $clog2(TABLE_DEPTH);

  // One packed quartet key: p in the top bits, s in the bottom bits.
  localparam int KEY_W = 4 * SHELL_W;

  // List of quartets already seen by an enumerate request.
  localparam int SEEN_DEPTH = 8;
  localparam int SEEN_IW    = $clog2(SEEN_DEPTH);
  localparam int SEEN_CW    = $clog2(SEEN_DEPTH + 1);

  // Request codes.
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_ENUM  = 2'd2
  } mode_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // A quartet in ordered form with the original slot of each position.
  typedef struct packed {
    logic [3:0][SHELL_W-1:0] v;
    logic [3:0][1:0]         src;
  } quad_t;

  // One stored enumerate result.
  typedef struct packed {
    quad_t              quad;
    logic [XFORM_W-1:0] xform;
  } seen_entry_t;

  // Control from the sequencer to the seen list.
  typedef struct packed {
    logic init;
    logic check;
  } seen_ctrl_t;

  // Pack four shells into one key that orders lexicographically.
  function automatic logic [KEY_W-1:0] pack_key(input logic [3:0][SHELL_W-1:0] v);
    pack_key = {v[0], v[1], v[2], v[3]};
  endfunction

endpackage

// ----- rtl/sqsf_ram.sv -----
module sqsf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/sqsf_order.sv -----
module sqsf_order (
  input  logic [3:0][sqsf_pkg::SHELL_W-1:0] shells,
  output sqsf_pkg::quad_t                   ordered
);

  logic [3:0][sqsf_pkg::SHELL_W-1:0] v;
  logic [3:0][1:0]                   src;
  logic [sqsf_pkg::SHELL_W-1:0]      tv;
  logic [1:0]                        ts;

  // Sort each pair ascending, then swap the pairs if the first is greater.
  always_comb begin
    v      = shells;
    src[0] = 2'd0;
    src[1] = 2'd1;
    src[2] = 2'd2;
    src[3] = 2'd3;
    tv     = '0;
    ts     = '0;
    if (v[0] > v[1]) begin
      tv = v[0];   v[0] = v[1];     v[1] = tv;
      ts = src[0]; src[0] = src[1]; src[1] = ts;
    end
    if (v[2] > v[3]) begin
      tv = v[2];   v[2] = v[3];     v[3] = tv;
      ts = src[2]; src[2] = src[3]; src[3] = ts;
    end
    if ((v[0] > v[2]) || ((v[0] == v[2]) && (v[1] > v[3]))) begin
      tv = v[0];   v[0] = v[2];     v[2] = tv;
      ts = src[0]; src[0] = src[2]; src[2] = ts;
      tv = v[1];   v[1] = v[3];     v[3] = tv;
      ts = src[1]; src[1] = src[3]; src[3] = ts;
    end
    ordered.v   = v;
    ordered.src = src;
  end

endmodule

// ----- rtl/sqsf_seen.sv -----
module sqsf_seen (
  input  logic                            clk,
  input  logic                            rst,
  input  sqsf_pkg::seen_ctrl_t            ctrl,
  input  logic [sqsf_pkg::KEY_W-1:0]      init_key,
  input  sqsf_pkg::quad_t                 quad,
  input  logic [sqsf_pkg::XFORM_W-1:0]    xform,
  input  logic [sqsf_pkg::SEEN_IW-1:0]    rd_idx,
  output logic [sqsf_pkg::SEEN_CW-1:0]    count,
  output sqsf_pkg::seen_entry_t           rd_entry
);

  logic [sqsf_pkg::KEY_W-1:0] keys [sqsf_pkg::SEEN_DEPTH];
  sqsf_pkg::seen_entry_t      ents [sqsf_pkg::SEEN_DEPTH];
  logic [sqsf_pkg::KEY_W-1:0] key;
  logic                       dup;
  logic                       insert;

  assign key = sqsf_pkg::pack_key(quad.v);

  // Compare the new image against every filled entry in parallel.
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < sqsf_pkg::SEEN_DEPTH; i++) begin
      if ((sqsf_pkg::SEEN_CW'(i) < count) && (keys[i] == key)) begin
        dup = 1'b1;
      end
    end
  end

  assign insert = ctrl.check && !dup &&
                  (count < sqsf_pkg::SEEN_CW'(sqsf_pkg::SEEN_DEPTH));

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.init) begin
      count <= sqsf_pkg::SEEN_CW'(1);
    end else if (insert) begin
      count <= count + sqsf_pkg::SEEN_CW'(1);
    end
  end

  // Entry storage; the first slot holds only the key of the quartet as given.
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      keys[0] <= init_key;
    end else if (insert) begin
      keys[count[sqsf_pkg::SEEN_IW-1:0]]       <= key;
      ents[count[sqsf_pkg::SEEN_IW-1:0]].quad  <= quad;
      ents[count[sqsf_pkg::SEEN_IW-1:0]].xform <= xform;
    end
  end

  assign rd_entry = ents[rd_idx];

endmodule

// ----- rtl/shell_quartet_symmetry_filter_core.sv -----
// Shell quartet symmetry filter.
// Configuration: cfg_valid/cfg_ready write active_transforms (cfg_ready is
// always high); write it only while the block is idle.
// Input channel (in_valid/in_stall): mode 0 loads one table entry and gives
// no result. Mode 1 asks whether a quartet is canonical and gives one result.
// Mode 2 lists the distinct ordered images of a quartet, one result per new
// image, or one empty result if there is none; the final result of a request
// carries last.
// Timing: the table is read for one active transform per
// cycle (two copies of the table, each with two read ports, give all four
// shells at once). Each image passes the table read, the ordering register and
// the check; once the last has been checked, the emit state loads the first
// result into the output register, and further results follow one per cycle
// while the output is not stalled. A new request is taken once the final
// result of the previous one sits in the output register.
// Output channel (out_valid/out_stall): a stall holds the output register and
// pauses the emission of further results.
// Reset clears the sequencer, the seen count and active_transforms; the image
// table holds no defined contents until it is loaded.
module shell_quartet_symmetry_filter_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [2:0]                   load_transform,
  input  logic [9:0]                   load_shell,
  input  logic [9:0]                   load_image,
  input  logic [9:0]                   shell_p,
  input  logic [9:0]                   shell_q,
  input  logic [9:0]                   shell_r,
  input  logic [9:0]                   shell_s,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_canonical,
  output logic                         quartet_valid,
  output logic [9:0]                   out_p,
  output logic [9:0]                   out_q,
  output logic [9:0]                   out_r,
  output logic [9:0]                   out_s,
  output logic [2:0]                   transform_used,
  output logic [1:0]                   slot0_from,
  output logic [1:0]                   slot1_from,
  output logic [1:0]                   slot2_from,
  output logic [1:0]                   slot3_from,
  output logic                         last
);

  sqsf_pkg::state_t state, state_next;

  logic [sqsf_pkg::XFORM_W-1:0]             active;
  logic [sqsf_pkg::XFORM_W-1:0]             n_use;
  logic                                     is_enum;
  logic [3:0][sqsf_pkg::SHELL_W-1:0]        sh;
  logic [3:0][sqsf_pkg::SHELL_W-1:0]        in_sh;
  logic [3:0][sqsf_pkg::SHELL_W-1:0]        rd_sh;
  logic [sqsf_pkg::XFORM_W-1:0]             t_rd;
  logic                                     vr;
  logic [sqsf_pkg::XFORM_W-1:0]             t_r;
  logic                                     va;
  logic [sqsf_pkg::XFORM_W-1:0]             t_a;
  sqsf_pkg::quad_t                          quad_a;
  sqsf_pkg::quad_t                          ordered;
  logic                                     canon;
  logic [sqsf_pkg::SEEN_IW-1:0]             emit_idx;
  logic [sqsf_pkg::SEEN_CW-1:0]             seen_count;
  sqsf_pkg::seen_entry_t                    entry;
  sqsf_pkg::seen_ctrl_t                     seen_ctrl;

  logic in_xfer;
  logic start;
  logic table_we;
  logic issue;
  logic run_done;
  logic out_free;
  logic emit_load;
  logic emit_last;
  logic no_results;

  assign cfg_ready = 1'b1;
  assign in_sh     = {shell_s, shell_r, shell_q, shell_p};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active <= cfg_data;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign no_results = seen_count <= sqsf_pkg::SEEN_CW'(1);
  assign emit_last  = !is_enum || no_results ||
                      (sqsf_pkg::SEEN_CW'(emit_idx) == seen_count - sqsf_pkg::SEEN_CW'(1));

  // Next state and control.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    start      = 1'b0;
    table_we   = 1'b0;
    issue      = 1'b0;
    run_done   = 1'b0;
    emit_load  = 1'b0;
    seen_ctrl  = '0;
    case (state)
      sqsf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_xfer) begin
          case (sqsf_pkg::mode_t'(mode))
            sqsf_pkg::MODE_LOAD: begin
              table_we = (load_transform < sqsf_pkg::XFORM_W'(sqsf_pkg::MAX_TRANSFORMS));
            end
            sqsf_pkg::MODE_QUERY: begin
              start      = 1'b1;
              state_next = sqsf_pkg::ST_RUN;
            end
            sqsf_pkg::MODE_ENUM: begin
              start          = 1'b1;
              seen_ctrl.init = 1'b1;
              state_next     = sqsf_pkg::ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      sqsf_pkg::ST_RUN: begin
        issue           = (t_rd < n_use);
        seen_ctrl.check = va && is_enum;
        run_done        = !issue && !vr && !va;
        if (run_done) begin
          state_next = sqsf_pkg::ST_EMIT;
        end
      end
      sqsf_pkg::ST_EMIT: begin
        emit_load = out_free;
        if (out_free && emit_last) begin
          state_next = sqsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sqsf_pkg::ST_IDLE;
      end
    endcase
  end

  // Request registers.
  always_ff @(posedge clk) begin
    if (start) begin
      sh      <= in_sh;
      n_use   <= (active > sqsf_pkg::XFORM_W'(sqsf_pkg::MAX_TRANSFORMS)) ?
                 sqsf_pkg::XFORM_W'(sqsf_pkg::MAX_TRANSFORMS) : active;
      is_enum <= (sqsf_pkg::mode_t'(mode) == sqsf_pkg::MODE_ENUM);
    end
  end

  // Transform pipeline: table read, then ordering, then the check.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_rd <= '0;
      vr   <= 1'b0;
      va   <= 1'b0;
    end else begin
      if (start) begin
        t_rd <= '0;
      end else if (issue) begin
        t_rd <= t_rd + sqsf_pkg::XFORM_W'(1);
      end
      vr <= issue;
      va <= vr;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_rd;
    t_a    <= t_r;
    quad_a <= ordered;
  end

  // Two copies of the image table, each serving two shells of the quartet.
  sqsf_ram #(
    .DEPTH (sqsf_pkg::TABLE_DEPTH),
    .WIDTH (sqsf_pkg::SHELL_W)
  ) u_ram_pq (
    .clk     (clk),
    .we      (table_we),
    .waddr   (sqsf_pkg::TABLE_AW'({load_transform, load_shell})),
    .wdata   (load_image),
    .re      (issue),
    .raddr_a (sqsf_pkg::TABLE_AW'({t_rd, sh[0]})),
    .raddr_b (sqsf_pkg::TABLE_AW'({t_rd, sh[1]})),
    .rdata_a (rd_sh[0]),
    .rdata_b (rd_sh[1])
  );

  sqsf_ram #(
    .DEPTH (sqsf_pkg::TABLE_DEPTH),
    .WIDTH (sqsf_pkg::SHELL_W)
  ) u_ram_rs (
    .clk     (clk),
    .we      (table_we),
    .waddr   (sqsf_pkg::TABLE_AW'({load_transform, load_shell})),
    .wdata   (load_image),
    .re      (issue),
    .raddr_a (sqsf_pkg::TABLE_AW'({t_rd, sh[2]})),
    .raddr_b (sqsf_pkg::TABLE_AW'({t_rd, sh[3]})),
    .rdata_a (rd_sh[2]),
    .rdata_b (rd_sh[3])
  );

  sqsf_order u_order (
    .shells  (rd_sh),
    .ordered (ordered)
  );

  // Canonical answer: in a query, cleared by any image ordering below the original.
  always_ff @(posedge clk) begin
    if (start) begin
      canon <= 1'b1;
    end else if (va && !is_enum &&
                 (sqsf_pkg::pack_key(quad_a.v) < sqsf_pkg::pack_key(sh))) begin
      canon <= 1'b0;
    end
  end

  sqsf_seen u_seen (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (seen_ctrl),
    .init_key (sqsf_pkg::pack_key(in_sh)),
    .quad     (quad_a),
    .xform    (t_a),
    .rd_idx   (emit_idx),
    .count    (seen_count),
    .rd_entry (entry)
  );

  // Emission index into the seen list; the first entry is the original.
  always_ff @(posedge clk) begin
    if (start) begin
      emit_idx <= sqsf_pkg::SEEN_IW'(1);
    end else if (emit_load) begin
      emit_idx <= emit_idx + sqsf_pkg::SEEN_IW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit_load;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      last <= emit_last;
      if (is_enum && !no_results) begin
        is_canonical   <= 1'b0;
        quartet_valid  <= 1'b1;
        out_p          <= entry.quad.v[0];
        out_q          <= entry.quad.v[1];
        out_r          <= entry.quad.v[2];
        out_s          <= entry.quad.v[3];
        transform_used <= entry.xform;
        slot0_from     <= entry.quad.src[0];
        slot1_from     <= entry.quad.src[1];
        slot2_from     <= entry.quad.src[2];
        slot3_from     <= entry.quad.src[3];
      end else begin
        is_canonical   <= !is_enum && canon;
        quartet_valid  <= 1'b0;
        out_p          <= '0;
        out_q          <= '0;
        out_r          <= '0;
        out_s          <= '0;
        transform_used <= '0;
        slot0_from     <= '0;
        slot1_from     <= '0;
        slot2_from     <= '0;
        slot3_from     <= '0;
      end
    end
  end

endmodule
